// ===== src/text_command_line_parser_core_defines.svh =====
// Assertion macros for the command line parser
`ifndef TEXT_COMMAND_LINE_PARSER_CORE_DEFINES_SVH
`define TEXT_COMMAND_LINE_PARSER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tclp check failed");
`define TCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tclp check failed");
`else
`define TCLP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/tclp_pkg.sv =====
// Shared constants, types and name table for the command line parser
`default_nettype none
package tclp_pkg;
    localparam int LINE_MAX = 256;
    localparam int NAME_MAX = 16;
    localparam int MAX_ARGS = 8;
    localparam int WORD_COUNT = 17;
    localparam int OFF_W = $clog2(LINE_MAX);
    localparam int NLEN_W = $clog2(NAME_MAX + 1);
    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int ENT_W = 16;
    localparam int MLEN_W = 5;

    localparam logic [4:0] KIND_BAD = 5'd0;
    localparam logic [4:0] KIND_UNKNOWN = 5'd1;
    localparam logic [4:0] KIND_BASE = 5'd2;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_OPEN = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_K = 8'h6B;
    localparam logic [7:0] CH_M = 8'h6D;

    typedef struct packed {
        logic [4:0]  kind;
        logic        id_present;
        logic [31:0] id_value;
        logic [3:0]  total;
        logic [CNT_W-1:0] count;
    } summary_t;

    function automatic logic [MLEN_W-1:0] word_len(input int w);
        case (w)
            0: return 5'd4;  1: return 5'd2;  2: return 5'd5;  3: return 5'd6;
            4: return 5'd4;  5: return 5'd6;  6: return 5'd7;  7: return 5'd4;
            8: return 5'd5;  9: return 5'd8;  10: return 5'd7; 11: return 5'd4;
            12: return 5'd6; 13: return 5'd6; 14: return 5'd6; 15: return 5'd4;
            default: return 5'd4;
        endcase
    endfunction

    function automatic logic [7:0] word_char(input int w, input int i);
        logic [63:0] s;
        int n;
        n = int'(word_len(w));
        case (w)
            0: s = 64'("down");      1: s = 64'("up");        2: s = 64'("press");
            3: s = 64'("string");    4: s = 64'("init");      5: s = 64'("isdown");
            6: s = 64'("disable");   7: s = 64'("mask");      8: s = 64'("remap");
            9: s = 64'("keyboard");  10: s = 64'("version");  11: s = 64'("info");
            12: s = 64'("device");   13: s = 64'("serial");   14: s = 64'("reboot");
            15: s = 64'("echo");
            default: s = 64'("baud");
        endcase
        return (i < n) ? s[8 * (n - 1 - i) +: 8] : 8'h00;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction
endpackage
`default_nettype wire

// ===== src/tclp_ram.sv =====
// Generic single-port-write RAM with registered read
`default_nettype none
module tclp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/tclp_name.sv =====
// Case-insensitive name matcher against the command word table
`default_nettype none
module tclp_name (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic clear,
    input  wire logic feed,
    input  wire logic [7:0] ch,
    output logic [4:0] kind
);
    import tclp_pkg::*;

    logic [WORD_COUNT-1:0] match_reg, match_next;
    logic [MLEN_W-1:0] mlen_reg, mlen_next;
    logic stopped_reg, stopped_next;
    logic [7:0] lc;

    always_comb
    begin
        match_next = match_reg;
        mlen_next = mlen_reg;
        stopped_next = stopped_reg;
        lc = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
        if (clear)
        begin
            match_next = '1;
            mlen_next = '0;
            stopped_next = 1'b0;
        end
        else if (feed && !stopped_reg)
        begin
            if (ch == 8'h00)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                for (int i = 0; i < WORD_COUNT; i++)
                begin
                    if (mlen_reg >= word_len(i) || word_char(i, int'(mlen_reg[2:0])) != lc)
                    begin
                        match_next[i] = 1'b0;
                    end
                end
                if (mlen_reg != 5'd31)
                begin
                    mlen_next = mlen_reg + 5'd1;
                end
            end
        end
    end

    always_comb
    begin
        kind = KIND_UNKNOWN;
        for (int i = WORD_COUNT - 1; i >= 0; i--)
        begin
            if (match_reg[i] && word_len(i) == mlen_reg)
            begin
                kind = KIND_BASE + 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '1;
            mlen_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            mlen_reg <= mlen_next;
            stopped_reg <= stopped_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/text_command_line_parser_core.sv =====
// Top level of the streaming command line parser
//
//  channel | handshake           | fields
//  in      | in_valid in_stall   | line_byte byte_present line_done
//  out     | out_valid out_stall | record_type .. final_record (8 fields)
//
// Take one byte per cycle while no line end is draining.
// A line end stalls the input while the kept tokens drain: ST_READ latches the summary
// and reads entry 0, ST_EMIT and ST_SUM pass each token record for its RAM read, then
// ST_EMIT sends the summary. A record held by out_stall extends this; in_stall is high then too.
// Reset returns to the whitespace phase; the token RAM is not cleared, only written
// entries are read.
`default_nettype none
`include "text_command_line_parser_core_defines.svh"
module text_command_line_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  line_byte,
    input  wire logic        byte_present,
    input  wire logic        line_done,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             record_type,
    output logic [7:0]       arg_start,
    output logic [7:0]       arg_end,
    output logic [4:0]       command_kind,
    output logic             id_present,
    output logic [31:0]      id_value,
    output logic [3:0]       arg_total,
    output logic             final_record
);
    import tclp_pkg::*;

    typedef enum logic [2:0] {
        PH_WS, PH_PREFIX, PH_NAME, PH_ARGS, PH_HASH, PH_DIGITS, PH_TAIL, PH_BAD
    } phase_t;
    typedef enum logic [1:0] { ST_RUN, ST_READ, ST_EMIT, ST_SUM } state_t;

    phase_t phase_reg, phase_next;
    state_t st_reg;
    logic [1:0] prefix_reg, prefix_next;
    logic [NLEN_W-1:0] nlen_reg, nlen_next;
    logic [1:0] quote_reg, quote_next;
    logic esc_reg, esc_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0] first_reg, first_next, tend_reg, tend_next;
    logic text_reg, text_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] id_reg, id_next;
    logic seen_reg, seen_next;
    logic close_reg, close_next;
    summary_t sum_reg;
    logic [CNT_W-1:0] rd_reg;

    logic take, feed_en, out_free, load_tok, load_sum;
    logic name_clear, name_feed;
    logic [7:0] name_ch;
    logic [4:0] kind;
    logic we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata, rdata;
    logic [7:0] c;
    logic [7:0] pos;
    logic sp, cl;

    assign take = in_valid && !in_stall;
    assign in_stall = (st_reg != ST_RUN) || (out_valid && out_stall);
    assign feed_en = take && byte_present;
    assign c = line_byte;
    assign pos = 8'(off_reg);
    assign out_free = !out_valid || !out_stall;
    assign load_tok = (st_reg == ST_EMIT) && out_free && (rd_reg < sum_reg.count);
    assign load_sum = (st_reg == ST_EMIT) && out_free && (rd_reg >= sum_reg.count);

    tclp_name u_name (
        .clk(clk), .rst_n(rst_n), .clear(name_clear), .feed(name_feed),
        .ch(name_ch), .kind(kind)
    );

    tclp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ARGS)) u_tok (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(rd_reg[IDX_W-1:0]), .rdata(rdata)
    );

    always_comb
    begin
        phase_next = phase_reg; prefix_next = prefix_reg; nlen_next = nlen_reg;
        quote_next = quote_reg; esc_next = esc_reg; off_next = off_reg;
        first_next = first_reg; tend_next = tend_reg; text_next = text_reg;
        cnt_next = cnt_reg; id_next = id_reg; seen_next = seen_reg;
        close_next = close_reg;
        name_feed = 1'b0; name_clear = load_sum; name_ch = c; we = 1'b0;
        waddr = cnt_reg[IDX_W-1:0]; wdata = {first_reg, tend_reg};
        sp = 1'b0; cl = 1'b0;
        if (feed_en)
        begin
            unique case (phase_reg)
                PH_WS:
                begin
                    if (!is_ws(c))
                    begin
                        if (c == CH_K)
                        begin
                            prefix_next = 2'd1; phase_next = PH_PREFIX; name_feed = 1'b1;
                        end
                        else if (c == CH_DOT)
                        begin
                            phase_next = PH_NAME;
                        end
                        else if (c == CH_OPEN)
                        begin
                            phase_next = PH_BAD;
                        end
                        else
                        begin
                            phase_next = PH_NAME; name_feed = 1'b1;
                            nlen_next = NLEN_W'(1);
                        end
                    end
                end
                PH_PREFIX:
                begin
                    if (prefix_reg == 2'd1 && c == CH_M)
                    begin
                        prefix_next = 2'd2; name_feed = 1'b1;
                    end
                    else if (prefix_reg == 2'd2 && c == CH_DOT)
                    begin
                        prefix_next = 2'd0; phase_next = PH_NAME; name_clear = 1'b1;
                    end
                    else if (c == CH_OPEN)
                    begin
                        prefix_next = 2'd0; phase_next = PH_ARGS;
                        nlen_next = NLEN_W'(prefix_reg);
                    end
                    else
                    begin
                        prefix_next = 2'd0; phase_next = PH_NAME; name_feed = 1'b1;
                        nlen_next = NLEN_W'(prefix_reg) + NLEN_W'(1);
                    end
                end
                PH_NAME:
                begin
                    if (c == CH_OPEN)
                    begin
                        phase_next = (nlen_reg == '0 || 32'(nlen_reg) >= NAME_MAX) ?
                            PH_BAD : PH_ARGS;
                    end
                    else
                    begin
                        name_feed = 1'b1;
                        if (32'(nlen_reg) < NAME_MAX) nlen_next = nlen_reg + 1'b1;
                    end
                end
                PH_ARGS:
                begin
                    if (esc_reg) esc_next = 1'b0;
                    else if (quote_reg != 2'd0)
                    begin
                        if (c == CH_BSL) esc_next = 1'b1;
                        else if (c == ((quote_reg == 2'd1) ? CH_SQ : CH_DQ)) quote_next = 2'd0;
                    end
                    else if (c == CH_SQ) quote_next = 2'd1;
                    else if (c == CH_DQ) quote_next = 2'd2;
                    else if (c == CH_CLOSE) cl = 1'b1;
                    else if (c == CH_COMMA) sp = 1'b1;
                    wdata = text_reg ? {first_reg, tend_reg} : {pos, pos};
                    if (cl)
                    begin
                        if (off_reg != '0 && 32'(cnt_reg) < MAX_ARGS)
                        begin
                            we = 1'b1; cnt_next = cnt_reg + 1'b1;
                        end
                        close_next = 1'b1; phase_next = PH_HASH;
                    end
                    else if (32'(off_reg) < LINE_MAX - 1)
                    begin
                        if (sp)
                        begin
                            if (32'(cnt_reg) < MAX_ARGS)
                            begin
                                we = 1'b1; cnt_next = cnt_reg + 1'b1;
                            end
                            text_next = 1'b0;
                        end
                        else if (!is_ws(c))
                        begin
                            if (!text_reg)
                            begin
                                first_next = pos; text_next = 1'b1;
                            end
                            tend_next = pos + 8'd1;
                        end
                        off_next = off_reg + 1'b1;
                    end
                end
                PH_HASH: phase_next = (c == CH_HASH) ? PH_DIGITS : PH_TAIL;
                PH_DIGITS:
                begin
                    if (c >= 8'h30 && c <= 8'h39)
                    begin
                        id_next = (id_reg << 3) + (id_reg << 1) + 32'(c - 8'h30);
                        seen_next = 1'b1;
                    end
                    else phase_next = PH_TAIL;
                end
                default: ;
            endcase
        end
        if (load_sum)
        begin
            phase_next = PH_WS; prefix_next = '0; nlen_next = '0; quote_next = '0;
            esc_next = 1'b0; off_next = '0; first_next = '0; tend_next = '0;
            text_next = 1'b0; cnt_next = '0; id_next = '0; seen_next = 1'b0;
            close_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WS; prefix_reg <= '0; nlen_reg <= '0; quote_reg <= '0;
            esc_reg <= 1'b0; off_reg <= '0; first_reg <= '0; tend_reg <= '0;
            text_reg <= 1'b0; cnt_reg <= '0; id_reg <= '0; seen_reg <= 1'b0;
            close_reg <= 1'b0; st_reg <= ST_RUN; rd_reg <= '0;
            out_valid <= 1'b0; sum_reg <= '0;
            record_type <= 1'b0; arg_start <= '0; arg_end <= '0; command_kind <= '0;
            id_present <= 1'b0; id_value <= '0; arg_total <= '0; final_record <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; prefix_reg <= prefix_next; nlen_reg <= nlen_next;
            quote_reg <= quote_next; esc_reg <= esc_next; off_reg <= off_next;
            first_reg <= first_next; tend_reg <= tend_next; text_reg <= text_next;
            cnt_reg <= cnt_next; id_reg <= id_next; seen_reg <= seen_next;
            close_reg <= close_next;
            if (load_tok || load_sum) out_valid <= 1'b1;
            else if (!out_stall) out_valid <= 1'b0;
            unique case (st_reg)
                ST_RUN:
                begin
                    if (take && line_done)
                    begin
                        st_reg <= ST_READ;
                        rd_reg <= '0;
                    end
                end
                ST_READ:
                begin
                    sum_reg.count <= close_reg ? cnt_reg : '0;
                    sum_reg.kind <= close_reg ? kind : KIND_BAD;
                    sum_reg.id_present <= close_reg && seen_reg;
                    sum_reg.id_value <= (close_reg && seen_reg) ? id_reg : 32'd0;
                    sum_reg.total <= close_reg ? 4'(cnt_reg) : 4'd0;
                    st_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (load_tok)
                    begin
                        record_type <= 1'b0;
                        arg_start <= rdata[15:8]; arg_end <= rdata[7:0];
                        command_kind <= '0; id_present <= 1'b0; id_value <= '0;
                        arg_total <= '0; final_record <= 1'b0;
                        rd_reg <= rd_reg + 1'b1;
                        st_reg <= ST_SUM;
                    end
                    else if (load_sum)
                    begin
                        record_type <= 1'b1;
                        arg_start <= '0; arg_end <= '0;
                        command_kind <= sum_reg.kind; id_present <= sum_reg.id_present;
                        id_value <= sum_reg.id_value; arg_total <= sum_reg.total;
                        final_record <= 1'b1;
                        st_reg <= ST_RUN;
                    end
                end
                ST_SUM: st_reg <= ST_EMIT;
                default: st_reg <= ST_RUN;
            endcase
        end
    end

    `TCLP_ASSERT_IMP(a_stall_drain, clk, rst_n, st_reg != ST_RUN, in_stall)
    `TCLP_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, 32'(cnt_reg) <= MAX_ARGS)
    `TCLP_ASSERT_NEXT(a_done_drain, clk, rst_n, take && line_done, st_reg == ST_READ)
endmodule
`default_nettype wire
